/* hdl/sscu_pkg.sv */
// Shared types, codes and constants of the stochastic cell update block.
`timescale 1ns / 1ps
package sscu_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int CODE_W    = 8;
    localparam int RATE_W    = 14;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SIZE_W    = 7;
    localparam int RAD_REG_W = 3;
    localparam int COORD_W   = 6;

    localparam logic [RATE_W-1:0] RATE_ONE = 14'd10000;

    // floor(x / 10000) for x below 2**27 as (x * RECIP_MUL) >> RECIP_SHIFT.
    localparam int MUL_W       = 28;
    localparam int PROD_W      = 27;
    localparam logic [MUL_W-1:0] RECIP_MUL = 28'd219902326;
    localparam int RECIP_SHIFT = 41;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_CODES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_S2D    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_I2D    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_S2I    = 3'd6;

    localparam logic [SIZE_W-1:0]    GRID_ROWS_RST   = 7'd64;
    localparam logic [SIZE_W-1:0]    GRID_COLS_RST   = 7'd64;
    localparam logic [RAD_REG_W-1:0] RADIUS_RST      = 3'd1;
    localparam logic [CFG_W-1:0]     STATE_CODES_RST = 32'h0302_0100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_FINISH
    } sscu_state_t;

endpackage

/* hdl/stochastic_sid_cell_update.sv */
// Top level of the stochastic susceptible/infected/dead cell update block.
//
// The block keeps a grid of 8-bit cell state codes in a RAM. Each item on
// the s_ channel is a write request, which stores one cell, or an update
// request, which returns the next state of one cell; every item yields
// exactly one item on the m_ channel. The user must write the configuration
// registers through cfg_wr_en, cfg_index and cfg_wdata only while the block
// is idle; the block itself does not enforce this. One item is processed at
// a time. A write goes from idle straight to the finish state, which loads
// the output register; a border, dead, infected or unknown cell passes the
// centre state first. A susceptible interior cell then reads its window
// cells through the single RAM read port, one per cycle, drains the last
// read and runs one survival step per infected window cell, stopping once
// survival reaches zero; each uses the shared multiplier twice (product, then
// reciprocal scaling by 1/10000). s_ready rises again in the same cycle in
// which the result appears in the output register. The output register holds
// a finished item while the receiver stalls, and the next item may be
// accepted meanwhile; its result waits until the register is free. Reset
// returns the sequencer to idle, empties the output register and restores
// the configuration defaults; the grid contents are undefined until written.
`timescale 1ns / 1ps
module stochastic_sid_cell_update
    import sscu_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [COORD_W-1:0]   s_cell_row,
    input  logic [COORD_W-1:0]   s_cell_col,
    input  logic [CODE_W-1:0]    s_cell_value,
    input  logic [RATE_W-1:0]    s_random_draw,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CODE_W-1:0]    m_next_state,
    output logic [7:0]           m_infected_count
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int DIM_W  = $clog2(MAX_ROWS + MAX_COLS + 2 * MAX_RADIUS + 256);
    localparam int AEXT_W = ADDR_W + DIM_W;
    localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int CNTX_W = CNT_W + 8;
    localparam int SUM_W  = RATE_W + 1;

    sscu_state_t state_reg, state_next;

    logic [SIZE_W-1:0]    grid_rows_reg;
    logic [SIZE_W-1:0]    grid_cols_reg;
    logic [RAD_REG_W-1:0] window_radius_reg;
    logic [CFG_W-1:0]     state_codes_reg;
    logic [RATE_W-1:0]    rate_s_to_dead_reg;
    logic [RATE_W-1:0]    rate_i_to_dead_reg;
    logic [RATE_W-1:0]    rate_s_to_i_reg;

    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [RATE_W-1:0]  draw_reg, draw_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]   row_hi_reg, row_hi_next;
    logic [COL_W-1:0]   col_lo_reg, col_lo_next;
    logic [COL_W-1:0]   col_hi_reg, col_hi_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   iter_reg, iter_next;
    logic [RATE_W-1:0]  surv_reg, surv_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CODE_W-1:0]  res_state_reg, res_state_next;
    logic [7:0]         res_count_reg, res_count_next;
    logic               m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]  m_next_state_reg, m_next_state_next;
    logic [7:0]         m_infected_count_reg, m_infected_count_next;

    logic [CODE_W-1:0] c_none, c_dead, c_sus, c_inf;
    logic [RATE_W-1:0] s2d_sat, i2d_sat, s2i_sat, keep;
    logic [DIM_W-1:0]  rows_d, cols_d, rad_d, row_d, col_d, in_row_d, in_col_d;
    logic [DIM_W-1:0]  r0_d, r1_d, c0_d, c1_d;
    logic              in_acc, in_store, cent_ok, interior;
    logic [CODE_W-1:0] cur;
    logic [CODE_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [AEXT_W-1:0] rd_addr_ext, wr_addr_ext;
    logic              ram_we;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_out;
    logic [SUM_W-1:0]  inf_limit;
    logic [CNTX_W-1:0] cnt_ext;
    logic [DIM_W-1:0]  scan_row_d, scan_col_d;

    assign c_none = state_codes_reg[7:0];
    assign c_dead = state_codes_reg[15:8];
    assign c_sus  = state_codes_reg[23:16];
    assign c_inf  = state_codes_reg[31:24];

    assign s2d_sat = (rate_s_to_dead_reg > RATE_ONE) ? RATE_ONE : rate_s_to_dead_reg;
    assign i2d_sat = (rate_i_to_dead_reg > RATE_ONE) ? RATE_ONE : rate_i_to_dead_reg;
    assign s2i_sat = (rate_s_to_i_reg > RATE_ONE) ? RATE_ONE : rate_s_to_i_reg;
    assign keep    = RATE_ONE - s2i_sat;

    assign rows_d = (DIM_W'(grid_rows_reg) > DIM_W'(MAX_ROWS)) ?
                    DIM_W'(MAX_ROWS) : DIM_W'(grid_rows_reg);
    assign cols_d = (DIM_W'(grid_cols_reg) > DIM_W'(MAX_COLS)) ?
                    DIM_W'(MAX_COLS) : DIM_W'(grid_cols_reg);
    assign rad_d  = (DIM_W'(window_radius_reg) > DIM_W'(MAX_RADIUS)) ?
                    DIM_W'(MAX_RADIUS) : DIM_W'(window_radius_reg);

    assign row_d    = DIM_W'(row_reg);
    assign col_d    = DIM_W'(col_reg);
    assign in_row_d = DIM_W'(s_cell_row);
    assign in_col_d = DIM_W'(s_cell_col);

    assign cent_ok  = (row_d < DIM_W'(MAX_ROWS)) && (col_d < DIM_W'(MAX_COLS));
    assign in_store = (in_row_d < DIM_W'(MAX_ROWS)) && (in_col_d < DIM_W'(MAX_COLS));
    assign cur      = cent_ok ? rd_data : '0;
    assign interior = (rows_d != '0) && (cols_d != '0) && (row_d != '0) &&
                      (col_d != '0) && (row_d + DIM_W'(1) < rows_d) &&
                      (col_d + DIM_W'(1) < cols_d);

    assign r0_d = (row_d > rad_d) ? row_d - rad_d : '0;
    assign c0_d = (col_d > rad_d) ? col_d - rad_d : '0;
    assign r1_d = (row_d + rad_d > rows_d - DIM_W'(1)) ? rows_d - DIM_W'(1) : row_d + rad_d;
    assign c1_d = (col_d + rad_d > cols_d - DIM_W'(1)) ? cols_d - DIM_W'(1) : col_d + rad_d;

    assign in_acc = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign scan_row_d  = DIM_W'(scan_row_reg);
    assign scan_col_d  = DIM_W'(scan_col_reg);
    assign wr_addr_ext = AEXT_W'(in_row_d) * AEXT_W'(MAX_COLS) + AEXT_W'(in_col_d);
    assign wr_addr     = wr_addr_ext[ADDR_W-1:0];
    assign rd_addr_ext = (state_reg == ST_IDLE) ? wr_addr_ext :
                         AEXT_W'(scan_row_d) * AEXT_W'(MAX_COLS) + AEXT_W'(scan_col_d);
    assign rd_addr     = rd_addr_ext[ADDR_W-1:0];
    assign ram_we      = in_acc && (s_req_type == REQ_WRITE) && in_store;

    sscu_ram #(
        .WIDTH(CODE_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (s_cell_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mul_a   = (state_reg == ST_DIV) ? MUL_W'(prod_reg) : MUL_W'(surv_reg);
    assign mul_b   = (state_reg == ST_DIV) ? RECIP_MUL : MUL_W'(keep);
    assign mul_out = mul_a * mul_b;

    assign inf_limit = SUM_W'(s2d_sat) + SUM_W'(RATE_ONE) - SUM_W'(surv_reg);
    assign cnt_ext   = CNTX_W'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg      <= GRID_ROWS_RST;
            grid_cols_reg      <= GRID_COLS_RST;
            window_radius_reg  <= RADIUS_RST;
            state_codes_reg    <= STATE_CODES_RST;
            rate_s_to_dead_reg <= '0;
            rate_i_to_dead_reg <= '0;
            rate_s_to_i_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_ROWS:   grid_rows_reg      <= cfg_wdata[SIZE_W-1:0];
                CFG_GRID_COLS:   grid_cols_reg      <= cfg_wdata[SIZE_W-1:0];
                CFG_RADIUS:      window_radius_reg  <= cfg_wdata[RAD_REG_W-1:0];
                CFG_STATE_CODES: state_codes_reg    <= cfg_wdata;
                CFG_RATE_S2D:    rate_s_to_dead_reg <= cfg_wdata[RATE_W-1:0];
                CFG_RATE_I2D:    rate_i_to_dead_reg <= cfg_wdata[RATE_W-1:0];
                CFG_RATE_S2I:    rate_s_to_i_reg    <= cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg              <= row_next;
        col_reg              <= col_next;
        draw_reg             <= draw_next;
        scan_row_reg         <= scan_row_next;
        scan_col_reg         <= scan_col_next;
        row_hi_reg           <= row_hi_next;
        col_lo_reg           <= col_lo_next;
        col_hi_reg           <= col_hi_next;
        pend_reg             <= pend_next;
        cnt_reg              <= cnt_next;
        iter_reg             <= iter_next;
        surv_reg             <= surv_next;
        prod_reg             <= prod_next;
        res_state_reg        <= res_state_next;
        res_count_reg        <= res_count_next;
        m_next_state_reg     <= m_next_state_next;
        m_infected_count_reg <= m_infected_count_next;
    end

    always_comb begin
        state_next            = state_reg;
        row_next              = row_reg;
        col_next              = col_reg;
        draw_next             = draw_reg;
        scan_row_next         = scan_row_reg;
        scan_col_next         = scan_col_reg;
        row_hi_next           = row_hi_reg;
        col_lo_next           = col_lo_reg;
        col_hi_next           = col_hi_reg;
        pend_next             = 1'b0;
        cnt_next              = cnt_reg;
        iter_next             = iter_reg;
        surv_next             = surv_reg;
        prod_next             = prod_reg;
        res_state_next        = res_state_reg;
        res_count_next        = res_count_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_next_state_next     = m_next_state_reg;
        m_infected_count_next = m_infected_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    row_next  = s_cell_row;
                    col_next  = s_cell_col;
                    draw_next = s_random_draw;
                    if (s_req_type == REQ_WRITE) begin
                        res_state_next = '0;
                        res_count_next = '0;
                        state_next     = ST_FINISH;
                    end else begin
                        state_next = ST_CENTRE;
                    end
                end
            end
            ST_CENTRE: begin
                res_count_next = '0;
                state_next     = ST_FINISH;
                if (!interior) begin
                    res_state_next = cur;
                end else if (cur == c_sus) begin
                    scan_row_next = r0_d[ROW_W-1:0];
                    scan_col_next = c0_d[COL_W-1:0];
                    row_hi_next   = r1_d[ROW_W-1:0];
                    col_lo_next   = c0_d[COL_W-1:0];
                    col_hi_next   = c1_d[COL_W-1:0];
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end else if (cur == c_inf) begin
                    res_state_next = (draw_reg < i2d_sat) ? c_dead : c_inf;
                end else if (cur == c_dead) begin
                    res_state_next = c_dead;
                end else begin
                    res_state_next = c_none;
                end
            end
            ST_SCAN: begin
                pend_next = 1'b1;
                if (pend_reg && (rd_data == c_inf)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (scan_col_reg == col_hi_reg) begin
                    scan_col_next = col_lo_reg;
                    if (scan_row_reg == row_hi_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        scan_row_next = scan_row_reg + ROW_W'(1);
                    end
                end else begin
                    scan_col_next = scan_col_reg + COL_W'(1);
                end
            end
            ST_DRAIN: begin
                if (pend_reg && (rd_data == c_inf)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                iter_next  = '0;
                surv_next  = RATE_ONE;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if ((iter_reg == cnt_reg) || (surv_reg == '0)) begin
                    state_next = ST_DECIDE;
                end else begin
                    prod_next  = mul_out[PROD_W-1:0];
                    iter_next  = iter_reg + CNT_W'(1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                surv_next  = mul_out[RECIP_SHIFT +: RATE_W];
                state_next = ST_MUL;
            end
            ST_DECIDE: begin
                if (draw_reg < s2d_sat) begin
                    res_state_next = c_dead;
                end else if (SUM_W'(draw_reg) < inf_limit) begin
                    res_state_next = c_inf;
                end else begin
                    res_state_next = c_sus;
                end
                res_count_next = (cnt_ext > CNTX_W'(255)) ? 8'hFF : cnt_ext[7:0];
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_next_state_next     = res_state_reg;
                    m_infected_count_next = res_count_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_next_state     = m_next_state_reg;
    assign m_infected_count = m_infected_count_reg;

endmodule

/* hdl/sscu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sscu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/sscu_checker.sv */
// Port-level assertion checker of the cell update block, bound to the top level.
`timescale 1ns / 1ps
module sscu_checker
    import sscu_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CODE_W-1:0] m_next_state,
    input logic [7:0]        m_infected_count
);

    logic [1:0] fly_reg, fly_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        fly_next = fly_reg;
        if (in_acc && !out_acc) begin
            fly_next = fly_reg + 2'd1;
        end else if (!in_acc && out_acc) begin
            fly_next = fly_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fly_reg <= '0;
        end else begin
            fly_reg <= fly_next;
        end
    end

    // At most one item is being worked on and one waits in the output register.
    a_fly_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fly_reg <= 2'd2)
        else $error("more than two items in flight");

    // When ready, the sequencer is empty, so only the output register may hold an item.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> fly_reg <= 2'd1)
        else $error("input ready while an item is still being processed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("ready did not fall after an accepted item");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not empty and ready after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_next_state) && $stable(m_infected_count)))
        else $error("stalled result item changed or vanished");

endmodule

bind stochastic_sid_cell_update sscu_checker u_sscu_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_next_state     (m_next_state),
    .m_infected_count (m_infected_count)
);

/* dv/tb_stochastic_sid_cell_update.sv */
// Self-checking testbench for the stochastic cell update block, with a grid predictor.
`timescale 1ns / 1ps
module tb_stochastic_sid_cell_update;
    import sscu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned GRID_DIM    = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic               req;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CODE_W-1:0]  value;
        logic [RATE_W-1:0]  draw;
    } cell_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] next_state;
        logic [7:0]        infected_count;
    } cell_result_t;

    typedef struct packed {
        cell_req_t    rq;
        logic         typed;
        cell_result_t want;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_WRITE;
    logic [COORD_W-1:0]   s_cell_row = '0;
    logic [COORD_W-1:0]   s_cell_col = '0;
    logic [CODE_W-1:0]    s_cell_value = '0;
    logic [RATE_W-1:0]    s_random_draw = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CODE_W-1:0]    m_next_state;
    logic [7:0]           m_infected_count;

    // Predictor copy of the grid and of the registers, already saturated.
    logic [CODE_W-1:0] grid_model [GRID_DIM][GRID_DIM];
    bit                written [GRID_DIM][GRID_DIM];
    int unsigned       rows_used = GRID_ROWS_RST;
    int unsigned       cols_used = GRID_COLS_RST;
    int unsigned       radius_used = RADIUS_RST;
    logic [CFG_W-1:0]  codes_word = STATE_CODES_RST;
    int unsigned       sus_death_rate = 0;
    int unsigned       inf_death_rate = 0;
    int unsigned       infect_rate = 0;

    cell_result_t  awaited_states[$];
    directed_row_t directed_rows [23];

    bit          steady = 1'b0;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done = 0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned items_sent = 0;
    int unsigned updates_sent = 0;
    int unsigned sus_updates = 0;
    int unsigned settings_run = 0;
    cell_result_t got;
    cell_result_t want_now;

    stochastic_sid_cell_update u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_cell_row       (s_cell_row),
        .s_cell_col       (s_cell_col),
        .s_cell_value     (s_cell_value),
        .s_random_draw    (s_random_draw),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_state     (m_next_state),
        .m_infected_count (m_infected_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, awaited_states.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random back-pressure, long holds on request, and the result check.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_holds_done != long_holds_asked) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_holds_done <= long_holds_done + 1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 18);
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{next_state: m_next_state, infected_count: m_infected_count};
            if (awaited_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: state %02h count %0d",
                             got.next_state, got.infected_count);
            end else begin
                want_now = awaited_states.pop_front();
                results_checked++;
                if (got.next_state !== want_now.next_state ||
                    got.infected_count !== want_now.infected_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Item %0d: expected state %02h count %0d, got state %02h count %0d",
                                 results_checked, want_now.next_state,
                                 want_now.infected_count, got.next_state,
                                 got.infected_count);
                end
            end
        end
    end

    function automatic bit on_rim(input int unsigned r, input int unsigned c);
        return rows_used == 0 || cols_used == 0 || r == 0 || c == 0 ||
               r + 1 >= rows_used || c + 1 >= cols_used;
    endfunction

    function automatic void window_of(input int unsigned r, input int unsigned c,
                                      output int unsigned r0, output int unsigned r1,
                                      output int unsigned c0, output int unsigned c1);
        r0 = (r > radius_used) ? r - radius_used : 0;
        c0 = (c > radius_used) ? c - radius_used : 0;
        r1 = (r + radius_used > rows_used - 1) ? rows_used - 1 : r + radius_used;
        c1 = (c + radius_used > cols_used - 1) ? cols_used - 1 : c + radius_used;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            CFG_GRID_ROWS:   rows_used = (data[6:0] > 7'd64) ? 64 : data[6:0];
            CFG_GRID_COLS:   cols_used = (data[6:0] > 7'd64) ? 64 : data[6:0];
            CFG_RADIUS:      radius_used = data[2:0];
            CFG_STATE_CODES: codes_word = data;
            CFG_RATE_S2D:    sus_death_rate = (data[13:0] > RATE_ONE) ? RATE_ONE : data[13:0];
            CFG_RATE_I2D:    inf_death_rate = (data[13:0] > RATE_ONE) ? RATE_ONE : data[13:0];
            CFG_RATE_S2I:    infect_rate = (data[13:0] > RATE_ONE) ? RATE_ONE : data[13:0];
            default: ;
        endcase
    endfunction

    function automatic cell_result_t next_cell_state(input cell_req_t rq);
        cell_result_t      res;
        int unsigned       r0, r1, c0, c1, i, j, hits, surv;
        logic [CODE_W-1:0] cur, none_c, dead_c, sus_c, inf_c;
        res = '0;
        {inf_c, sus_c, dead_c, none_c} = codes_word;
        if (rq.req == REQ_WRITE) begin
            grid_model[rq.row][rq.col] = rq.value;
            written[rq.row][rq.col] = 1'b1;
            return res;
        end
        cur = grid_model[rq.row][rq.col];
        if (on_rim(rq.row, rq.col)) begin
            res.next_state = cur;
            return res;
        end
        if (cur == sus_c) begin
            sus_updates++;
            window_of(rq.row, rq.col, r0, r1, c0, c1);
            hits = 0;
            for (i = r0; i <= r1; i++)
                for (j = c0; j <= c1; j++)
                    if (grid_model[i][j] == inf_c)
                        hits++;
            surv = RATE_ONE;
            for (i = 0; i < hits && surv != 0; i++)
                surv = surv * (RATE_ONE - infect_rate) / RATE_ONE;
            if (rq.draw < sus_death_rate)
                res.next_state = dead_c;
            else if (rq.draw < sus_death_rate + RATE_ONE - surv)
                res.next_state = inf_c;
            else
                res.next_state = sus_c;
            res.infected_count = (hits > 255) ? 8'd255 : hits[7:0];
        end else if (cur == inf_c) begin
            res.next_state = (rq.draw < inf_death_rate) ? dead_c : inf_c;
        end else if (cur == dead_c) begin
            res.next_state = dead_c;
        end else begin
            res.next_state = none_c;
        end
        return res;
    endfunction

    // Finds a cell that an update of (r, c) would read but that holds nothing yet.
    function automatic bit find_gap(input int unsigned r, input int unsigned c,
                                    output int unsigned gr, output int unsigned gc);
        int unsigned r0, r1, c0, c1, i, j;
        gr = r;
        gc = c;
        if (on_rim(r, c))
            return !written[r][c];
        window_of(r, c, r0, r1, c0, c1);
        for (i = r0; i <= r1; i++)
            for (j = c0; j <= c1; j++)
                if (!written[i][j]) begin
                    gr = i;
                    gc = j;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned used);
        if (used >= 3 && $urandom_range(0, 99) < 80)
            return COORD_W'($urandom_range(0, (used - 1 > 9) ? 9 : used - 1));
        return COORD_W'($urandom_range(0, GRID_DIM - 1));
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0:       return codes_word[7:0];
            1:       return codes_word[15:8];
            2, 3, 4: return codes_word[23:16];
            5, 6, 7: return codes_word[31:24];
            default: return CODE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cell_req_t random_request();
        cell_req_t   rq;
        int unsigned gr, gc;
        rq.req = ($urandom_range(0, 99) < 70) ? REQ_UPDATE : REQ_WRITE;
        rq.row = pick_coord(rows_used);
        rq.col = pick_coord(cols_used);
        rq.value = pick_code();
        rq.draw = ($urandom_range(0, 19) == 0) ? RATE_W'($urandom_range(10000, 16383))
                                               : RATE_W'($urandom_range(0, 9999));
        if (rq.req == REQ_UPDATE && find_gap(rq.row, rq.col, gr, gc)) begin
            rq.req = REQ_WRITE;
            rq.row = COORD_W'(gr);
            rq.col = COORD_W'(gc);
        end
        return rq;
    endfunction

    function automatic directed_row_t row_of(input logic req, input int unsigned r,
                                             input int unsigned c, input int unsigned v,
                                             input int unsigned d, input logic typed,
                                             input int unsigned ns);
        directed_row_t dr;
        dr.rq = '{req: req, row: COORD_W'(r), col: COORD_W'(c), value: CODE_W'(v),
                  draw: RATE_W'(d)};
        dr.typed = typed;
        dr.want = '{next_state: CODE_W'(ns), infected_count: 8'd0};
        return dr;
    endfunction

    task automatic offer(input cell_req_t rq, input logic typed, input cell_result_t want);
        cell_result_t pred;
        if (!steady && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rq.req;
        s_cell_row <= rq.row;
        s_cell_col <= rq.col;
        s_cell_value <= rq.value;
        s_random_draw <= rq.draw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = next_cell_state(rq);
        awaited_states.push_back(typed ? want : pred);
        items_sent++;
        if (rq.req == REQ_UPDATE)
            updates_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_states.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_reg(idx, data);
    endtask

    task automatic run_phase(input int unsigned rows, input int unsigned cols,
                             input int unsigned rad, input logic [CFG_W-1:0] codes,
                             input int unsigned s2d, input int unsigned i2d,
                             input int unsigned s2i, input int unsigned count,
                             input bit pressure);
        int unsigned k;
        drain_results();
        repeat (6) @(posedge aclk);
        if (settings_run == 0)
            write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_STATE_CODES, codes);
        write_reg(CFG_RATE_S2D, s2d);
        write_reg(CFG_RATE_I2D, i2d);
        write_reg(CFG_RATE_S2I, s2i);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_run++;
        for (k = 0; k < count; k++) begin
            if (pressure && k == 20)
                long_holds_asked++;
            if (pressure && k == 40)
                steady = 1'b1;
            if (pressure && k == 110)
                steady = 1'b0;
            if (pressure && k == 150)
                drain_results();
            offer(random_request(), 1'b0, '0);
        end
    endtask

    initial begin
        int unsigned k;
        directed_rows[0]  = row_of(REQ_WRITE,   0,  0, 8'h02,     0, 1'b1, 8'h00);
        directed_rows[1]  = row_of(REQ_UPDATE,  0,  0, 8'hFF,     0, 1'b1, 8'h02);
        directed_rows[2]  = row_of(REQ_WRITE,  63, 63, 8'hFF,     0, 1'b1, 8'h00);
        directed_rows[3]  = row_of(REQ_UPDATE, 63, 63, 8'h00, 16383, 1'b1, 8'hFF);
        directed_rows[4]  = row_of(REQ_WRITE,   0,  1, 8'h03,     0, 1'b1, 8'h00);
        directed_rows[5]  = row_of(REQ_WRITE,   0,  2, 8'h03,     0, 1'b1, 8'h00);
        directed_rows[6]  = row_of(REQ_WRITE,   1,  0, 8'h01,     0, 1'b1, 8'h00);
        directed_rows[7]  = row_of(REQ_WRITE,   1,  2, 8'h00,     0, 1'b1, 8'h00);
        directed_rows[8]  = row_of(REQ_WRITE,   2,  0, 8'h03,     0, 1'b1, 8'h00);
        directed_rows[9]  = row_of(REQ_WRITE,   2,  1, 8'h02,     0, 1'b1, 8'h00);
        directed_rows[10] = row_of(REQ_WRITE,   2,  2, 8'hAA,     0, 1'b1, 8'h00);
        directed_rows[11] = row_of(REQ_WRITE,   1,  1, 8'h02,     0, 1'b1, 8'h00);
        directed_rows[12] = row_of(REQ_UPDATE,  1,  1, 8'h00,     0, 1'b0, 8'h00);
        directed_rows[13] = row_of(REQ_UPDATE,  1,  1, 8'h00,  9999, 1'b0, 8'h00);
        directed_rows[14] = row_of(REQ_WRITE,   1,  1, 8'h03,     0, 1'b1, 8'h00);
        directed_rows[15] = row_of(REQ_UPDATE,  1,  1, 8'h00,     0, 1'b1, 8'h03);
        directed_rows[16] = row_of(REQ_WRITE,   1,  1, 8'h01,     0, 1'b1, 8'h00);
        directed_rows[17] = row_of(REQ_UPDATE,  1,  1, 8'h00,  5000, 1'b1, 8'h01);
        directed_rows[18] = row_of(REQ_WRITE,   1,  1, 8'hAA,     0, 1'b1, 8'h00);
        directed_rows[19] = row_of(REQ_UPDATE,  1,  1, 8'h00,  9999, 1'b1, 8'h00);
        directed_rows[20] = row_of(REQ_WRITE,  42, 21, 8'h5A,     0, 1'b1, 8'h00);
        directed_rows[21] = row_of(REQ_WRITE,   1,  1, 8'h00,     0, 1'b1, 8'h00);
        directed_rows[22] = row_of(REQ_UPDATE,  1,  1, 8'h00,     0, 1'b1, 8'h00);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < 23; k++)
            offer(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);

        run_phase(5, 6, 1, 32'h0302_0100, 1500, 5000, 2500, 110, 1'b0);
        run_phase(64, 64, 7, 32'h0302_0100, 0, 10000, 10000, 90, 1'b0);
        run_phase(0, 127, 3, $urandom(), 300, 300, 300, 40, 1'b0);
        run_phase(1, 64, 0, 32'h0302_0100, 9000, 9000, 9000, 30, 1'b0);
        // Susceptible and infected share a code, so the susceptible match wins.
        run_phase(3, 3, 0, 32'h0707_05FF, 16383, 12000, 400, 100, 1'b0);
        run_phase(127, 10, 2, 32'h8040_2010, 16383, 12000, 300, 100, 1'b0);
        run_phase(9, 9, 4, $urandom(), $urandom_range(0, 16383),
                  $urandom_range(0, 16383), $urandom_range(0, 16383), 110, 1'b0);
        run_phase(64, 64, 1, 32'h0302_0100, 800, 2000, 1200, 220, 1'b1);

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d items (%0d updates, %0d susceptible interior) over %0d settings.",
                 items_sent, updates_sent, sus_updates, settings_run + 1);
        $display("Checked %0d results; %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
